>>> rtl/blpg_pkg.sv
package blpg_pkg;

  localparam int MAX_DIM   = 64;
  localparam int CNT_W     = $clog2(MAX_DIM);
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int ERR_W     = 8;
  localparam int ADDR_W    = 12;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;
  } in_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               write_enable;
    logic               last_pixel;
  } out_pix_t;

  typedef struct packed {
    logic load;
    logic emit;
  } blpg_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic at_end;
  } blpg_sts_t;

endpackage

>>> rtl/blpg_ctrl.sv
module blpg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  blpg_pkg::blpg_sts_t sts,
  output blpg_pkg::blpg_cmd_t cmd
);
  import blpg_pkg::*;

  typedef enum logic {IDLE, WALK} state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_stall  = (state_r != IDLE);
    cmd.load  = (state_r == IDLE) && in_valid;
    cmd.emit  = (state_r == WALK) && sts.slot_free;
    state_nxt = state_r;
    unique case (state_r)
      IDLE: begin
        if (in_valid) state_nxt = WALK;
      end
      WALK: begin
        if (sts.slot_free && sts.at_end) state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/blpg_dp.sv
module blpg_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blpg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  blpg_pkg::in_req_t                     in_req,
  input  blpg_pkg::blpg_cmd_t                   cmd,
  output blpg_pkg::blpg_sts_t                   sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output blpg_pkg::out_pix_t                    out_pix
);
  import blpg_pkg::*;

  logic [DIM_W-1:0]          fw_r, fh_r;
  logic [COORD_W-1:0]        cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic signed [ERR_W-1:0]   err_r;
  logic [DIM_W-1:0]          dx_r, ndy_r;
  logic                      sxn_r, syn_r;
  logic [COLOR_W-1:0]        color_r;
  logic [CNT_W-1:0]          cnt_r;
  out_pix_t                  out_r;
  logic                      out_valid_r;

  logic [DIM_W-1:0]          ld_dx, ld_ady, ld_ndy;
  logic signed [ERR_W-1:0]   ld_err;
  logic signed [ERR_W:0]     e2, dy9, dx9;
  logic                      step_x, step_y;
  logic signed [ERR_W-1:0]   err_nxt;
  logic [COORD_W-1:0]        x_nxt, y_nxt;
  logic [2*COORD_W:0]        addr_full;
  out_pix_t                  pix;

  always_comb begin
    ld_dx  = (in_req.end_x > in_req.start_x)
             ? DIM_W'(in_req.end_x - in_req.start_x)
             : DIM_W'(in_req.start_x - in_req.end_x);
    ld_ady = (in_req.end_y > in_req.start_y)
             ? DIM_W'(in_req.end_y - in_req.start_y)
             : DIM_W'(in_req.start_y - in_req.end_y);
    ld_ndy = DIM_W'(-ld_ady);
    ld_err = ERR_W'({1'b0, ld_dx}) + ERR_W'({ld_ndy[DIM_W-1], ld_ndy});

    e2     = {err_r, 1'b0};
    dy9    = {{2{ndy_r[DIM_W-1]}}, ndy_r};
    dx9    = {2'b00, dx_r};
    step_x = (e2 >= dy9);
    step_y = (e2 <= dx9);
    err_nxt = err_r
            + (step_x ? ERR_W'({ndy_r[DIM_W-1], ndy_r}) : ERR_W'(0))
            + (step_y ? ERR_W'({1'b0, dx_r}) : ERR_W'(0));
    x_nxt  = step_x ? (sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1) : cur_x_r;
    y_nxt  = step_y ? (syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1) : cur_y_r;

    sts.at_end    = ((cur_x_r == end_x_r) && (cur_y_r == end_y_r))
                  || (cnt_r == CNT_W'(MAX_DIM - 1));
    sts.slot_free = !out_valid_r || !out_stall;

    addr_full = (2*COORD_W+1)'(cur_y_r) * (2*COORD_W+1)'(fw_r)
              + (2*COORD_W+1)'(cur_x_r);
    pix.pixel_x       = cur_x_r;
    pix.pixel_y       = cur_y_r;
    pix.pixel_address = addr_full[ADDR_W-1:0];
    pix.pixel_color   = color_r;
    pix.write_enable  = ({1'b0, cur_x_r} < fw_r) && ({1'b0, cur_y_r} < fh_r);
    pix.last_pixel    = sts.at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FRAME_WIDTH_RST;
      fh_r        <= FRAME_HEIGHT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  fw_r <= cfg_data;
          REG_FRAME_HEIGHT: fh_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= in_req.start_x;
      cur_y_r <= in_req.start_y;
      end_x_r <= in_req.end_x;
      end_y_r <= in_req.end_y;
      dx_r    <= ld_dx;
      ndy_r   <= ld_ndy;
      sxn_r   <= !(in_req.start_x < in_req.end_x);
      syn_r   <= !(in_req.start_y < in_req.end_y);
      err_r   <= ld_err;
      color_r <= in_req.line_color;
      cnt_r   <= '0;
    end else if (cmd.emit) begin
      cur_x_r <= x_nxt;
      cur_y_r <= y_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_r;

endmodule

>>> rtl/bresenham_line_pixel_generator_core.sv
// Bresenham line pixel generator.
// Request channel: in_valid / in_stall carry one line request (start and end
// point, 32-bit color). A request is taken when in_valid is high and in_stall
// low; in_stall stays high while a line is being walked.
// Result channel: out_valid / out_stall carry one pixel per transfer, start
// to end point inclusive, the end point flagged with last_pixel. Each pixel
// has its frame address y*frame_width+x and a write enable for in-frame
// pixels.
// Walk: a taken request is loaded into the walk registers, then each pixel
// is registered in the output register, one pixel per cycle unless the
// receiver stalls; a line has up to 64 pixels. The walk is a single-step error
// update loop in the datapath, one pixel per iteration.
// A stalled receiver freezes the walk; the pending pixel holds in the output
// register. The next request is taken while the last pixel still waits.
// cfg_we / cfg_index / cfg_data write frame_width (index 0) and frame_height
// (index 1); write only while idle. Reset (rst_n low, synchronous) returns to
// idle, drops out_valid and sets both frame sizes to 64.
module bresenham_line_pixel_generator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blpg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  blpg_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output blpg_pkg::out_pix_t               out_pix
);
  import blpg_pkg::*;

  blpg_cmd_t cmd;
  blpg_sts_t sts;

  blpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blpg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

endmodule

>>> bench/bresenham_line_pixel_generator_core_test.sv
module bresenham_line_pixel_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blpg_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic {ROW_LINE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_req_t   req;
    bit        typed;
    out_pix_t  want;
    int        width;
    int        height;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_pix_t              out_pix;

  out_pix_t  pixel_q[$];
  plan_row_t plan[$];

  int frame_w = 64;
  int frame_h = 64;
  int pen_x, pen_y, pen_err;

  int send_gap = 18;
  int stall_pct = 56;
  int fail_count = 0;
  int cycle_count = 0;
  int lines_sent = 0;
  int pixels_seen = 0;
  int directed_lines = 0;

  bresenham_line_pixel_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels outstanding", cycle_count, pixel_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // all-octant walk; every visited pixel is queued, end point flagged
  task automatic trace_line(input in_req_t r);
    int x1, y1, dx, dy, sx, sy, e2, n;
    bit done;
    out_pix_t p;
    pen_x = int'(r.start_x);
    pen_y = int'(r.start_y);
    x1 = int'(r.end_x);
    y1 = int'(r.end_y);
    dx = (x1 > pen_x) ? x1 - pen_x : pen_x - x1;
    dy = (y1 > pen_y) ? pen_y - y1 : y1 - pen_y;
    sx = (pen_x < x1) ? 1 : -1;
    sy = (pen_y < y1) ? 1 : -1;
    pen_err = dx + dy;
    n = 0;
    done = 1'b0;
    while (!done) begin
      done = (pen_x == x1 && pen_y == y1) || (n + 1 >= MAX_DIM);
      p.pixel_x       = COORD_W'(pen_x);
      p.pixel_y       = COORD_W'(pen_y);
      p.pixel_address = ADDR_W'(pen_y * frame_w + pen_x);
      p.pixel_color   = r.line_color;
      p.write_enable  = (pen_x < frame_w) && (pen_y < frame_h);
      p.last_pixel    = done;
      pixel_q.push_back(p);
      n++;
      if (!done) begin
        e2 = 2 * pen_err;
        if (e2 >= dy) begin
          pen_err += dy;
          pen_x += sx;
        end
        if (e2 <= dx) begin
          pen_err += dx;
          pen_y += sy;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", out_pix.pixel_x, out_pix.pixel_y);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        check_field("pixel_x", 32'(want.pixel_x), 32'(out_pix.pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(out_pix.pixel_y));
        check_field("pixel_address", 32'(want.pixel_address), 32'(out_pix.pixel_address));
        check_field("pixel_color", want.pixel_color, out_pix.pixel_color);
        check_field("write_enable", 32'(want.write_enable), 32'(out_pix.write_enable));
        check_field("last_pixel", 32'(want.last_pixel), 32'(out_pix.last_pixel));
      end
      pixels_seen++;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_line(input in_req_t r);
    while ($urandom_range(0, 99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  function automatic plan_row_t mk_line(input int x0, input int y0, input int x1, input int y1,
                                        input logic [31:0] color);
    plan_row_t row;
    row.kind           = ROW_LINE;
    row.req.start_x    = COORD_W'(x0);
    row.req.start_y    = COORD_W'(y0);
    row.req.end_x      = COORD_W'(x1);
    row.req.end_y      = COORD_W'(y1);
    row.req.line_color = color;
    row.typed          = 1'b0;
    row.want           = '0;
    row.width          = 0;
    row.height         = 0;
    return row;
  endfunction

  // single-point line, result written out by hand
  function automatic plan_row_t mk_point(input int x, input int y, input logic [31:0] color,
                                         input int addr, input bit we);
    plan_row_t row;
    row = mk_line(x, y, x, y, color);
    row.typed              = 1'b1;
    row.want.pixel_x       = COORD_W'(x);
    row.want.pixel_y       = COORD_W'(y);
    row.want.pixel_address = ADDR_W'(addr);
    row.want.pixel_color   = color;
    row.want.write_enable  = we;
    row.want.last_pixel    = 1'b1;
    return row;
  endfunction

  function automatic plan_row_t mk_cfg(input int w, input int h);
    plan_row_t row;
    row = mk_line(0, 0, 0, 0, '0);
    row.kind   = ROW_CFG;
    row.width  = w;
    row.height = h;
    return row;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  function automatic in_req_t random_line();
    in_req_t r;
    int x0, y0, x1, y1, len;
    x0 = $urandom_range(0, 63);
    y0 = $urandom_range(0, 63);
    x1 = $urandom_range(0, 63);
    y1 = $urandom_range(0, 63);
    len = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: begin
        x1 = x0;
        y1 = y0;
      end
      1: y1 = y0;
      2: x1 = x0;
      3: begin
        x1 = clamp_coord((x0 < 32) ? x0 + len : x0 - len);
        y1 = clamp_coord((y0 < 32) ? y0 + len : y0 - len);
      end
      4, 5, 6: begin
        x1 = clamp_coord(x0 + int'($urandom_range(0, 12)) - 6);
        y1 = clamp_coord(y0 + int'($urandom_range(0, 12)) - 6);
      end
      default: ;
    endcase
    r.start_x    = COORD_W'(x0);
    r.start_y    = COORD_W'(y0);
    r.end_x      = COORD_W'(x1);
    r.end_y      = COORD_W'(y1);
    r.line_color = $urandom;
    return r;
  endfunction

  initial begin
    in_req_t r;
    int ph, k, w, h;
    plan.push_back(mk_point(0, 0, 32'h0000_0000, 0, 1'b1));
    plan.push_back(mk_point(63, 63, 32'hFFFF_FFFF, 4095, 1'b1));
    plan.push_back(mk_line(0, 0, 63, 0, 32'hA5A5_A5A5));
    plan.push_back(mk_line(63, 0, 0, 63, 32'h5A5A_5A5A));
    plan.push_back(mk_line(0, 63, 0, 0, 32'h0F0F_0F0F));
    plan.push_back(mk_line(63, 63, 0, 0, 32'hF0F0_F0F0));
    plan.push_back(mk_line(32, 32, 40, 35, 32'h1111_1111));
    plan.push_back(mk_line(32, 32, 35, 40, 32'h2222_2222));
    plan.push_back(mk_line(32, 32, 29, 40, 32'h3333_3333));
    plan.push_back(mk_line(32, 32, 24, 35, 32'h4444_4444));
    plan.push_back(mk_line(32, 32, 24, 29, 32'h5555_5555));
    plan.push_back(mk_line(32, 32, 29, 24, 32'h6666_6666));
    plan.push_back(mk_line(32, 32, 35, 24, 32'h7777_7777));
    plan.push_back(mk_line(32, 32, 40, 29, 32'h8888_8888));
    plan.push_back(mk_cfg(0, 0));
    plan.push_back(mk_point(5, 9, 32'h1234_5678, 5, 1'b0));
    plan.push_back(mk_line(2, 3, 20, 11, 32'hDEAD_BEEF));
    plan.push_back(mk_cfg(127, 127));
    plan.push_back(mk_point(63, 63, 32'h5A5A_5A5A, 3968, 1'b1));
    plan.push_back(mk_line(0, 0, 63, 63, 32'hCAFE_F00D));
    plan.push_back(mk_cfg(1, 64));
    plan.push_back(mk_line(3, 0, 0, 10, 32'h8000_0001));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_frame(plan[i].width, plan[i].height);
      end else begin
        send_line(plan[i].req);
        if (plan[i].typed) pixel_q.push_back(plan[i].want);
        else trace_line(plan[i].req);
        directed_lines++;
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin w = 0;   h = 127; end
        1: begin w = 127; h = 0;   end
        2: begin w = 1;   h = 64;  end
        3: begin w = 64;  h = 1;   end
        4: begin
          w = $urandom_range(1, 64);
          h = $urandom_range(1, 64);
        end
        default: begin w = 64; h = 37; end
      endcase
      send_gap  = (ph < 2) ? 18 : ((ph < 4) ? 56 : 0);
      stall_pct = (ph < 2) ? 56 : ((ph < 4) ? 18 : 0);
      wait_drained();
      write_frame(w, h);
      for (k = 0; k < 25; k++) begin
        if ($urandom_range(0, 19) == 0) wait_drained();
        r = random_line();
        send_line(r);
        trace_line(r);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Drew %0d lines (%0d directed) and checked %0d pixels", lines_sent, directed_lines,
             pixels_seen);
    $display("Frame sizes ran from zero through 64 to oversized 127, all octants and points.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
